[hw/rtl/dbh_pkg.sv]
`timescale 1ns / 1ps
// Package for the multi-input debounce core: widths, register indexes, lane config type.
// No dependencies.
package dbh_pkg;

    localparam int unsigned LANES_MAX  = 8;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNT_LIMITS   = 3'd0,
        REG_ON_THRESHOLDS  = 3'd1,
        REG_OFF_THRESHOLDS = 3'd2,
        REG_INVERT_MASK    = 3'd3
    } t_reg_idx;

    localparam logic [CFG_DATA_W-1:0] COUNT_LIMITS_RST   = 64'h0101_0101_0101_0101;
    localparam logic [CFG_DATA_W-1:0] ON_THRESHOLDS_RST  = 64'h0101_0101_0101_0101;
    localparam logic [CFG_DATA_W-1:0] OFF_THRESHOLDS_RST = 64'h0;
    localparam logic [LANES_MAX-1:0]  INVERT_MASK_RST    = 8'h0;

    typedef struct packed {
        logic [CNT_W-1:0] limit;
        logic [CNT_W-1:0] on_th;
        logic [CNT_W-1:0] off_th;
    } t_lane_cfg;

endpackage

[hw/rtl/dbh_lane.sv]
`timescale 1ns / 1ps
// One debounce lane: saturating up/down counter with on/off hysteresis.
// Depends on dbh_pkg.
module dbh_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_raw,
    input  dbh_pkg::t_lane_cfg  i_cfg,
    output logic                o_level_next
);

    logic [dbh_pkg::CNT_W-1:0] r_cnt;
    logic [dbh_pkg::CNT_W-1:0] n_cnt;
    logic                      r_level;
    logic                      n_level;

    always_comb begin
        n_cnt   = r_cnt;
        n_level = r_level;
        if (i_raw) begin
            if (r_cnt < i_cfg.limit) begin
                n_cnt = r_cnt + dbh_pkg::CNT_W'(1);
            end
            if (n_cnt >= i_cfg.on_th) begin
                n_level = 1'b1;
            end
        end else begin
            if (r_cnt != '0) begin
                n_cnt = r_cnt - dbh_pkg::CNT_W'(1);
            end
            if (n_cnt <= i_cfg.off_th) begin
                n_level = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_level <= 1'b0;
        end else if (i_step) begin
            r_cnt   <= n_cnt;
            r_level <= n_level;
        end
    end

    // Result of this tick is the updated level
    assign o_level_next = n_level;

endmodule

[hw/rtl/dbh_merge.sv]
`timescale 1ns / 1ps
// Merge stage: applies invert mask to lane levels, packs the vector and
// buffers it in an output register plus skid register. Depends on dbh_pkg.
module dbh_merge #(
    parameter int unsigned NUM_LANES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [NUM_LANES-1:0]          i_levels,
    input  logic [dbh_pkg::LANES_MAX-1:0] i_invert_mask,
    output logic                          o_full,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dbh_pkg::LANES_MAX-1:0] o_filtered_bits
);

    logic [dbh_pkg::LANES_MAX-1:0] w_result;
    logic                          r_out_valid;
    logic [dbh_pkg::LANES_MAX-1:0] r_out_data;
    logic                          r_skid_valid;
    logic [dbh_pkg::LANES_MAX-1:0] r_skid_data;
    logic                          w_pop;

    // Unused lanes read as zero, never inverted
    always_comb begin
        w_result = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            w_result[i] = i_levels[i] ^ i_invert_mask[i];
        end
    end

    assign w_pop = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_pop) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= i_push;
                end
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (i_push) begin
                r_out_data <= w_result;
            end
        end else if (i_push) begin
            r_skid_data <= w_result;
        end
    end

    assign o_full          = r_skid_valid;
    assign o_out_valid     = r_out_valid;
    assign o_filtered_bits = r_out_data;

endmodule

[hw/rtl/multi_input_debounce_hysteresis_core.sv]
`timescale 1ns / 1ps
// Top level of the multi-input debounce core: config registers, lanes, merge.
// Depends on dbh_pkg, dbh_lane, dbh_merge.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_raw_bits): one transaction is one
//   sampling tick, bit i is the raw level of lane i.
//   Output channel (o_out_valid / i_out_ready / o_filtered_bits): one transaction
//   per input tick, in order, carrying the debounced and optionally inverted
//   levels. Lanes at or above NUM_LANES read as 0.
//   Config port: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 count limits, 1 on thresholds, 2 off thresholds, 3 invert mask);
//   other indexes are ignored. Write only while no transaction is in flight.
//   Result: lane levels are computed combinationally and captured at the accepting
//   edge in the output register, or the skid register while the output is stalled.
//   Throughput: one tick per cycle while o_in_ready is high; each lane does one
//   count step and two compares per tick.
//   Stall: an output register and a skid register hold up to two results;
//   o_in_ready drops only when both are occupied.
//   Reset (synchronous, i_rst_n low): counters and levels clear, registers
//   return to their defaults, both output slots empty.
module multi_input_debounce_hysteresis_core #(
    parameter int unsigned NUM_LANES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [dbh_pkg::LANES_MAX-1:0]   i_raw_bits,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [dbh_pkg::LANES_MAX-1:0]   o_filtered_bits,
    input  logic                            i_cfg_we,
    input  logic [dbh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dbh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [dbh_pkg::CFG_DATA_W-1:0] r_count_limits;
    logic [dbh_pkg::CFG_DATA_W-1:0] r_on_thresholds;
    logic [dbh_pkg::CFG_DATA_W-1:0] r_off_thresholds;
    logic [dbh_pkg::LANES_MAX-1:0]  r_invert_mask;
    logic                           w_full;
    logic                           w_accept;
    logic [NUM_LANES-1:0]           w_levels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_limits   <= dbh_pkg::COUNT_LIMITS_RST;
            r_on_thresholds  <= dbh_pkg::ON_THRESHOLDS_RST;
            r_off_thresholds <= dbh_pkg::OFF_THRESHOLDS_RST;
            r_invert_mask    <= dbh_pkg::INVERT_MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dbh_pkg::REG_COUNT_LIMITS:   r_count_limits   <= i_cfg_data;
                dbh_pkg::REG_ON_THRESHOLDS:  r_on_thresholds  <= i_cfg_data;
                dbh_pkg::REG_OFF_THRESHOLDS: r_off_thresholds <= i_cfg_data;
                dbh_pkg::REG_INVERT_MASK: begin
                    r_invert_mask <= i_cfg_data[dbh_pkg::LANES_MAX-1:0];
                end
                default: ;
            endcase
        end
    end

    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && !w_full;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        dbh_pkg::t_lane_cfg w_cfg;

        assign w_cfg.limit  = r_count_limits[dbh_pkg::CNT_W*g +: dbh_pkg::CNT_W];
        assign w_cfg.on_th  = r_on_thresholds[dbh_pkg::CNT_W*g +: dbh_pkg::CNT_W];
        assign w_cfg.off_th = r_off_thresholds[dbh_pkg::CNT_W*g +: dbh_pkg::CNT_W];

        dbh_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_step       (w_accept),
            .i_raw        (i_raw_bits[g]),
            .i_cfg        (w_cfg),
            .o_level_next (w_levels[g])
        );
    end

    dbh_merge #(
        .NUM_LANES (NUM_LANES)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (w_accept),
        .i_levels        (w_levels),
        .i_invert_mask   (r_invert_mask),
        .o_full          (w_full),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_filtered_bits (o_filtered_bits)
    );

endmodule

[hw/rtl/dbh_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the multi-input debounce core, bound to the top level.
// Depends on dbh_pkg and multi_input_debounce_hysteresis_core.
module dbh_port_checker #(
    parameter int unsigned NUM_LANES = 8
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [dbh_pkg::LANES_MAX-1:0]   o_filtered_bits
);

    // Buffers empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Every accepted tick leaves a result pending in the next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted transaction produced no result");

    // Backpressure only when a result is already waiting
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // Lanes beyond NUM_LANES read as zero
    a_unused_lanes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_filtered_bits >> NUM_LANES) == '0))
        else $error("unused lane bit set");

    // Stalled result holds its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_filtered_bits)))
        else $error("stalled result changed");

endmodule

bind multi_input_debounce_hysteresis_core dbh_port_checker #(
    .NUM_LANES (NUM_LANES)
) u_dbh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_filtered_bits (o_filtered_bits)
);

[tb/dbh_checker.sv]
`timescale 1ns / 1ps
// Transaction checker for the multi-input debounce core: mirrors lane counters and
// levels, queues the filtered vector of each accepted tick and compares results in order.
// Depends on dbh_pkg.
module dbh_checker #(
    parameter int unsigned NUM_LANES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [dbh_pkg::LANES_MAX-1:0]    i_raw_bits,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [dbh_pkg::LANES_MAX-1:0]    i_filtered_bits,
    input  logic                             i_cfg_we,
    input  logic [dbh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dbh_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                               o_mismatch_count,
    output int                               o_pending_count
);

    logic [dbh_pkg::CFG_DATA_W-1:0] cfg_limits;
    logic [dbh_pkg::CFG_DATA_W-1:0] cfg_on;
    logic [dbh_pkg::CFG_DATA_W-1:0] cfg_off;
    logic [dbh_pkg::LANES_MAX-1:0]  cfg_invert;

    logic [dbh_pkg::CNT_W-1:0]      lane_cnt [dbh_pkg::LANES_MAX];
    logic                           lane_lvl [dbh_pkg::LANES_MAX];

    logic [dbh_pkg::LANES_MAX-1:0]  filtered_q [$];

    // One sampling tick across all lanes; updates the mirrored state.
    function automatic logic [dbh_pkg::LANES_MAX-1:0] debounce_tick(
        input logic [dbh_pkg::LANES_MAX-1:0] raw);
        logic [dbh_pkg::CNT_W-1:0]     cnt;
        logic [dbh_pkg::LANES_MAX-1:0] levels;
        levels = '0;
        for (int ln = 0; ln < dbh_pkg::LANES_MAX; ln++) begin
            if (ln < NUM_LANES) begin
                cnt = lane_cnt[ln];
                if (raw[ln]) begin
                    if (cnt < cfg_limits[dbh_pkg::CNT_W*ln +: dbh_pkg::CNT_W])
                        cnt = cnt + 1'b1;
                    if (cnt >= cfg_on[dbh_pkg::CNT_W*ln +: dbh_pkg::CNT_W])
                        lane_lvl[ln] = 1'b1;
                end else begin
                    // no clamp when the limit was lowered under the count
                    if (cnt != '0) cnt = cnt - 1'b1;
                    if (cnt <= cfg_off[dbh_pkg::CNT_W*ln +: dbh_pkg::CNT_W])
                        lane_lvl[ln] = 1'b0;
                end
                lane_cnt[ln] = cnt;
                levels[ln]   = lane_lvl[ln] ^ cfg_invert[ln];
            end
        end
        return levels;
    endfunction

    always @(posedge i_clk) begin
        logic [dbh_pkg::LANES_MAX-1:0] want;
        if (!i_rst_n) begin
            cfg_limits = dbh_pkg::COUNT_LIMITS_RST;
            cfg_on     = dbh_pkg::ON_THRESHOLDS_RST;
            cfg_off    = dbh_pkg::OFF_THRESHOLDS_RST;
            cfg_invert = dbh_pkg::INVERT_MASK_RST;
            for (int ln = 0; ln < dbh_pkg::LANES_MAX; ln++) begin
                lane_cnt[ln] = '0;
                lane_lvl[ln] = 1'b0;
            end
            filtered_q.delete();
            o_mismatch_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dbh_pkg::REG_COUNT_LIMITS:   cfg_limits = i_cfg_data;
                    dbh_pkg::REG_ON_THRESHOLDS:  cfg_on     = i_cfg_data;
                    dbh_pkg::REG_OFF_THRESHOLDS: cfg_off    = i_cfg_data;
                    dbh_pkg::REG_INVERT_MASK:
                        cfg_invert = i_cfg_data[dbh_pkg::LANES_MAX-1:0];
                    default: ;
                endcase
            end
            // output side first so a stray result cannot match this edge's input
            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %02h",
                             $time, i_filtered_bits);
                    o_mismatch_count++;
                end else begin
                    want = filtered_q.pop_front();
                    if (i_filtered_bits !== want) begin
                        $display("%0t: filtered_bits mismatch, expected %02h actual %02h",
                                 $time, want, i_filtered_bits);
                        o_mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                filtered_q.push_back(debounce_tick(i_raw_bits));
        end
        o_pending_count = filtered_q.size();
    end

endmodule

[tb/tb_multi_input_debounce_hysteresis_core.sv]
`timescale 1ns / 1ps
// Testbench top for multi_input_debounce_hysteresis_core: directed and random tick
// streams over several register settings, random stalls on both channels.
// Depends on dbh_pkg, dbh_checker and the core RTL.
module tb_multi_input_debounce_hysteresis_core;

    localparam int unsigned NUM_LANES    = 8;
    localparam int          RESET_CYCLES = 10;
    localparam int          DRAIN_CYCLES = 4;

    typedef enum int {
        PH_TYPICAL,
        PH_SWAPPED,
        PH_RANDOM,
        PH_ZERO,
        PH_MAX
    } t_phase_kind;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [dbh_pkg::LANES_MAX-1:0]  raw_bits = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [dbh_pkg::LANES_MAX-1:0]  filtered_bits;
    logic                           cfg_we = 1'b0;
    logic [dbh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dbh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int mismatch_count;
    int pending_count;
    bit sender_burst = 1'b0;

    multi_input_debounce_hysteresis_core #(
        .NUM_LANES(NUM_LANES)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_raw_bits     (raw_bits),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_filtered_bits(filtered_bits),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    dbh_checker #(
        .NUM_LANES(NUM_LANES)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_raw_bits      (raw_bits),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_filtered_bits (filtered_bits),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_mismatch_count(mismatch_count),
        .o_pending_count (pending_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Receiver back-pressure, with occasional long stretches of steady ready.
    initial begin
        int stall;
        int run;
        @(posedge clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            run = ($urandom_range(19, 0) == 0) ? $urandom_range(200, 50) : $urandom_range(6, 1);
            repeat (run) @(posedge clk);
        end
    end

    task automatic send_tick(input logic [dbh_pkg::LANES_MAX-1:0] raw);
        int gap;
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_bits <= raw;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop sending and wait until every queued result has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [dbh_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [dbh_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic write_unused_reg();
        logic [dbh_pkg::CFG_IDX_W-1:0] bad_idx;
        bad_idx = dbh_pkg::CFG_IDX_W'($urandom_range((1 << dbh_pkg::CFG_IDX_W) - 1,
                                                     int'(dbh_pkg::REG_INVERT_MASK) + 1));
        write_reg(bad_idx, {$urandom, $urandom});
    endtask

    task automatic run_phase(input t_phase_kind kind, input int n_items, input bit hold_mid);
        logic [dbh_pkg::CFG_DATA_W-1:0] lim_w;
        logic [dbh_pkg::CFG_DATA_W-1:0] on_w;
        logic [dbh_pkg::CFG_DATA_W-1:0] off_w;
        logic [dbh_pkg::CFG_DATA_W-1:0] low_lim_w;
        logic [dbh_pkg::LANES_MAX-1:0]  inv_w;
        logic [dbh_pkg::LANES_MAX-1:0]  target;
        logic [dbh_pkg::LANES_MAX-1:0]  raw;
        int lim;
        int on_v;
        int off_v;
        int flip_div;
        int noise_pct;
        int mid_sel;
        wait_drained();
        for (int ln = 0; ln < dbh_pkg::LANES_MAX; ln++) begin
            case (kind)
                PH_TYPICAL: begin
                    lim   = $urandom_range(10, 1);
                    on_v  = $urandom_range(lim, 1);
                    off_v = $urandom_range(on_v - 1, 0);
                end
                PH_SWAPPED: begin
                    lim   = $urandom_range(12, 1);
                    on_v  = $urandom_range(lim, 0);
                    off_v = $urandom_range(255, on_v);
                end
                PH_RANDOM: begin
                    lim   = $urandom_range(255, 0);
                    on_v  = $urandom_range(255, 0);
                    off_v = $urandom_range(255, 0);
                end
                PH_ZERO: begin
                    lim   = 0;
                    on_v  = 0;
                    off_v = 0;
                end
                default: begin
                    lim   = 255;
                    on_v  = 255;
                    off_v = 255;
                end
            endcase
            lim_w[dbh_pkg::CNT_W*ln +: dbh_pkg::CNT_W]     = 8'(lim);
            on_w[dbh_pkg::CNT_W*ln +: dbh_pkg::CNT_W]      = 8'(on_v);
            off_w[dbh_pkg::CNT_W*ln +: dbh_pkg::CNT_W]     = 8'(off_v);
            low_lim_w[dbh_pkg::CNT_W*ln +: dbh_pkg::CNT_W] = 8'($urandom_range(3, 0));
        end
        case (kind)
            PH_ZERO: inv_w = '0;
            PH_MAX:  inv_w = '1;
            default: inv_w = 8'($urandom_range(255, 0));
        endcase
        flip_div  = (kind == PH_MAX) ? 400 : (kind == PH_ZERO) ? 4 : 12;
        noise_pct = (kind == PH_MAX) ? 5 : 30;
        if ($urandom_range(1, 0) == 1) write_unused_reg();
        write_reg(dbh_pkg::REG_COUNT_LIMITS, lim_w);
        write_reg(dbh_pkg::REG_ON_THRESHOLDS, on_w);
        write_reg(dbh_pkg::REG_OFF_THRESHOLDS, off_w);
        write_reg(dbh_pkg::REG_INVERT_MASK, {56'($urandom), inv_w});
        cfg_we <= 1'b0;

        sender_burst = ($urandom_range(3, 0) == 0);
        target = (kind == PH_MAX) ? '1 : 8'($urandom_range(255, 0));
        for (int k = 0; k < n_items; k++) begin
            if (k == n_items / 2) begin
                mid_sel = $urandom_range(2, 0);
                if (hold_mid || mid_sel == 0) wait_drained();
                if (mid_sel == 0) begin
                    // limits under the present counts
                    write_reg(dbh_pkg::REG_COUNT_LIMITS, low_lim_w);
                    cfg_we <= 1'b0;
                end
            end
            if ($urandom_range(99, 0) < noise_pct) begin
                raw = 8'($urandom);
            end else begin
                if ($urandom_range(flip_div - 1, 0) == 0) target ^= 8'($urandom_range(255, 1));
                raw = target;
                if ($urandom_range(4, 0) == 0) raw ^= 8'(1 << $urandom_range(7, 0));
            end
            send_tick(raw);
        end
        sender_burst = 1'b0;
    endtask

    initial begin
        t_phase_kind plan [11];
        plan = '{PH_TYPICAL, PH_TYPICAL, PH_SWAPPED, PH_RANDOM, PH_TYPICAL, PH_ZERO,
                 PH_TYPICAL, PH_SWAPPED, PH_RANDOM, PH_TYPICAL, PH_TYPICAL};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: limit 1, on 1, off 0
        send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'hFF);
        send_tick(8'h00);
        send_tick(8'h00);
        send_tick(8'hA5);
        send_tick(8'h5A);
        send_tick(8'hFF);

        // on threshold 0 and off threshold 255: a high sets, a low clears
        wait_drained();
        write_reg(dbh_pkg::REG_COUNT_LIMITS, 64'h0303_0303_0303_0303);
        write_reg(dbh_pkg::REG_ON_THRESHOLDS, 64'h0);
        write_reg(dbh_pkg::REG_OFF_THRESHOLDS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(dbh_pkg::REG_INVERT_MASK, 64'hF0);
        write_unused_reg();
        cfg_we <= 1'b0;
        send_tick(8'hFF);
        send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'h0F);

        // limit lowered under the count: no clamp, still counts down
        wait_drained();
        write_reg(dbh_pkg::REG_COUNT_LIMITS, 64'h0404_0404_0404_0404);
        write_reg(dbh_pkg::REG_ON_THRESHOLDS, 64'h0202_0202_0202_0202);
        write_reg(dbh_pkg::REG_OFF_THRESHOLDS, 64'h0101_0101_0101_0101);
        write_reg(dbh_pkg::REG_INVERT_MASK, 64'h00);
        cfg_we <= 1'b0;
        repeat (4) send_tick(8'hFF);
        wait_drained();
        write_reg(dbh_pkg::REG_COUNT_LIMITS, 64'h0101_0101_0101_0101);
        cfg_we <= 1'b0;
        repeat (2) send_tick(8'hFF);
        repeat (3) send_tick(8'h00);

        run_phase(PH_MAX, 400, 1'b0);
        foreach (plan[p]) run_phase(plan[p], 112, p == 1);

        wait_drained();
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/dbh_pkg.sv
hw/rtl/dbh_lane.sv
hw/rtl/dbh_merge.sv
hw/rtl/multi_input_debounce_hysteresis_core.sv
hw/rtl/dbh_checker.sv
tb/dbh_checker.sv
tb/tb_multi_input_debounce_hysteresis_core.sv
